/* rtl/sdpc_pkg.sv */
// ----------------------------------------------------------------------------
// sdpc_pkg: shared types and constants of the serial device poll controller
// Holds the command codes, the item and result records and the frame codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpc_pkg;

  // commands sent to the device
  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_ENABLE_KEYS = 3'd1,
    CMD_GET_KEY     = 3'd2,
    CMD_GET_ROOM    = 3'd3,
    CMD_GET_VOLUME  = 3'd4
  } cmd_t;

  // kind of an accepted item
  typedef enum logic {
    ITEM_TICK = 1'b0,
    ITEM_BYTE = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    cmd_t        send_command;
    logic        heartbeat;
    logic        frame_done;
    logic        device_error;
    logic [7:0]  source_code;
    logic [7:0]  mute_state;
    logic [7:0]  power_off_state;
    logic [7:0]  volume_level;
    logic [7:0]  key_events_on;
    logic        room_state_request;
    logic        volume_key_active;
    logic        source_key_request;
  } result_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ACK_TIMEOUT   = 2'd0,
    REG_ROUND_GAP     = 2'd1,
    REG_VOLUME_PERIOD = 2'd2
  } cfg_reg_t;

  localparam int          CFG_INDEX_W         = 2;
  localparam int          CFG_DATA_W          = 16;
  localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd100;
  localparam logic [15:0] ROUND_GAP_RESET     = 16'd100;
  localparam logic [7:0]  VOLUME_PERIOD_RESET = 8'd10;

  // frame header bits
  localparam int HDR_ERROR_BIT  = 7;
  localparam int HDR_NOTIFY_BIT = 3;

  // frame opcodes
  localparam logic [15:0] OP_KEY_EVENT  = 16'h0104;
  localparam logic [15:0] OP_ACK        = 16'h0100;
  localparam logic [15:0] OP_SOURCE     = 16'h010A;
  localparam logic [15:0] OP_ROOM       = 16'h0111;
  localparam logic [15:0] OP_VOLUME     = 16'h0115;
  localparam logic [15:0] OP_KEY_ENABLE = 16'h011B;

  // key codes
  localparam logic [7:0] KEY_POWER    = 8'h01;
  localparam logic [7:0] KEY_MUTE     = 8'h4C;
  localparam logic [7:0] KEY_VOL_UP   = 8'h02;
  localparam logic [7:0] KEY_VOL_DOWN = 8'h03;
  localparam logic [7:0] KEY_SOURCE   = 8'hD3;

  // key request flag bits
  localparam int KF_ROOM   = 0;
  localparam int KF_VOLUME = 1;
  localparam int KF_SOURCE = 2;

  // bytes of a frame that are kept for decoding
  localparam int FRAME_STORE   = 6;
  localparam int FRAME_STORE_W = 3;

endpackage

`default_nettype wire

/* rtl/sdpc_front.sv */
// ----------------------------------------------------------------------------
// sdpc_front: input side of the poll controller
// Accepts items, tags them as tick or byte and holds them in a two entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic           operation,
  input  wire logic [7:0]     rx_byte,
  output sdpc_pkg::item_t     item,
  output logic                item_valid,
  input  wire logic           item_take
);
  import sdpc_pkg::*;

  localparam int DEPTH = 2;

  item_t      mem [DEPTH];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;
  item_t      tagged_item;

  assign full       = (count == 2'(DEPTH));
  assign item_valid = (count != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_comb begin
    tagged_item.kind = operation ? ITEM_BYTE : ITEM_TICK;
    tagged_item.data = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= tagged_item;
  end

  assign item = mem[rd_ptr];

endmodule

`default_nettype wire

/* rtl/sdpc_engine.sv */
// ----------------------------------------------------------------------------
// sdpc_engine: back part of the poll controller
// Runs the poll sequence, the ack wait, frame assembly and frame decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpc_engine #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sdpc_pkg::CFG_DATA_W-1:0]  cfg_value,
  input  wire sdpc_pkg::item_t                  item,
  input  wire logic                             item_valid,
  output logic                                  item_take,
  input  wire logic                             res_full,
  output sdpc_pkg::result_t                     result,
  output logic                                  result_push
);
  import sdpc_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES);

  typedef enum logic [4:0] {
    STEP_START  = 5'b00001,
    STEP_KEY    = 5'b00010,
    STEP_ROOM   = 5'b00100,
    STEP_VOLUME = 5'b01000,
    STEP_GAP    = 5'b10000
  } poll_step_t;

  // configuration
  logic [15:0] ack_timeout;
  logic [15:0] round_gap;
  logic [7:0]  volume_period;

  // state
  logic [15:0]  ack_wait, ack_wait_next;
  logic [15:0]  gap, gap_next;
  poll_step_t   step, step_next;
  logic [7:0]   vcount, vcount_next;
  logic [7:0]   fbytes [FRAME_STORE];
  logic [7:0]   fbytes_next [FRAME_STORE];
  logic [LEN_W-1:0] frem, frem_next;
  logic [LEN_W-1:0] fpos, fpos_next;
  logic         err, err_next;
  logic [7:0]   rv_source, rv_source_next;
  logic [7:0]   rv_mute, rv_mute_next;
  logic [7:0]   rv_off, rv_off_next;
  logic [7:0]   rv_volume, rv_volume_next;
  logic [7:0]   rv_keyev, rv_keyev_next;
  logic [2:0]   kflags, kflags_next;

  logic         fire;
  cmd_t         cmd;
  cmd_t         step_cmd;
  cmd_t         step_req;
  logic         hb;
  logic         done;
  logic         frame_live;
  logic         tick_free;
  logic [7:0]   len_clamped;
  logic [15:0]  opcode;
  logic [7:0]   key_code;

  assign fire        = item_valid && !res_full;
  assign item_take   = fire;
  assign result_push = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout   <= ACK_TIMEOUT_RESET;
      round_gap     <= ROUND_GAP_RESET;
      volume_period <= VOLUME_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACK_TIMEOUT:   ack_timeout   <= cfg_value;
        REG_ROUND_GAP:     round_gap     <= cfg_value;
        REG_VOLUME_PERIOD: volume_period <= cfg_value[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ack_wait_next  = ack_wait;
    gap_next       = gap;
    step_next      = step;
    vcount_next    = vcount;
    fbytes_next    = fbytes;
    frem_next      = frem;
    fpos_next      = fpos;
    err_next       = err;
    rv_source_next = rv_source;
    rv_mute_next   = rv_mute;
    rv_off_next    = rv_off;
    rv_volume_next = rv_volume;
    rv_keyev_next  = rv_keyev;
    kflags_next    = kflags;
    cmd            = CMD_NONE;
    step_cmd       = CMD_NONE;
    step_req       = CMD_NONE;
    hb             = 1'b0;
    done           = 1'b0;
    frame_live     = 1'b0;
    tick_free      = 1'b0;
    len_clamped    = (item.data > 8'(MAX_FRAME_BYTES)) ? 8'(MAX_FRAME_BYTES) : item.data;
    opcode         = 16'd0;
    key_code       = 8'd0;

    if (item.kind == ITEM_BYTE) begin
      // frame assembly
      if (frem == '0) begin
        if (len_clamped != 8'd0) begin
          frem_next  = LEN_W'(len_clamped - 8'd1);
          fpos_next  = '0;
          frame_live = 1'b1;
        end
      end else begin
        if (fpos < LEN_W'(FRAME_STORE)) fbytes_next[fpos[FRAME_STORE_W-1:0]] = item.data;
        fpos_next  = fpos + LEN_W'(1);
        frem_next  = frem - LEN_W'(1);
        frame_live = 1'b1;
      end

      if (frame_live && frem_next == '0) begin
        fpos_next = '0;
        done      = 1'b1;
        opcode    = {fbytes_next[1], fbytes_next[2]};
        key_code  = fbytes_next[5];
        if (fbytes_next[0][HDR_ERROR_BIT]) begin
          err_next = 1'b1;
        end else if (fbytes_next[0][HDR_NOTIFY_BIT]) begin
          if (opcode == OP_KEY_EVENT) begin
            kflags_next = 3'b000;
            if (fbytes_next[3] == 8'd0) begin
              if (key_code inside {KEY_POWER, KEY_MUTE}) begin
                kflags_next[KF_ROOM] = 1'b1;
              end else if (key_code inside {KEY_VOL_UP, KEY_VOL_DOWN}) begin
                kflags_next[KF_VOLUME] = 1'b1;
              end else if (key_code == KEY_SOURCE) begin
                kflags_next[KF_SOURCE] = 1'b1;
              end
            end
          end
        end else begin
          unique case (opcode)
            OP_ACK:        ack_wait_next  = 16'd0;
            OP_SOURCE:     rv_source_next = fbytes_next[3];
            OP_ROOM: begin
              rv_mute_next = fbytes_next[4];
              rv_off_next  = fbytes_next[5];
            end
            OP_VOLUME:     rv_volume_next = fbytes_next[3];
            OP_KEY_ENABLE: rv_keyev_next  = fbytes_next[3];
            default: ;
          endcase
        end
      end
    end else begin
      // poll tick
      if (ack_wait != 16'd0) begin
        ack_wait_next = ack_wait - 16'd1;
        if (ack_wait == 16'd1) begin
          frem_next = '0;
          fpos_next = '0;
        end
      end else begin
        if (vcount != 8'd0) begin
          if (vcount == volume_period) begin
            cmd           = CMD_GET_VOLUME;
            ack_wait_next = ack_timeout;
          end
          vcount_next = kflags[KF_VOLUME] ? vcount - 8'd1 : 8'd0;
          gap_next    = round_gap;
        end
        if (gap_next != 16'd0) begin
          gap_next = gap_next - 16'd1;
        end else begin
          tick_free = 1'b1;
        end
      end

      if (tick_free) begin
        unique case (step)
          STEP_START: begin
            hb = 1'b1;
            if (rv_keyev == 8'd0) begin
              step_next = STEP_KEY;
              step_req  = CMD_ENABLE_KEYS;
            end else begin
              step_next = STEP_ROOM;
              step_req  = CMD_GET_KEY;
            end
          end
          STEP_KEY: begin
            step_next = STEP_ROOM;
            step_req  = CMD_GET_KEY;
          end
          STEP_ROOM: begin
            step_next = STEP_VOLUME;
            step_req  = CMD_GET_ROOM;
          end
          STEP_VOLUME: begin
            step_next = STEP_GAP;
            step_req  = CMD_GET_VOLUME;
          end
          STEP_GAP: begin
            gap_next  = round_gap;
            step_next = STEP_START;
          end
          default: step_next = STEP_START;
        endcase
        // one command at a time while an ack is pending
        if (step_req != CMD_NONE && ack_wait_next == 16'd0) begin
          ack_wait_next = ack_timeout;
          step_cmd      = step_req;
        end
        if (cmd == CMD_NONE) cmd = step_cmd;
      end
    end

    // fast volume poll reload
    if (kflags_next[KF_VOLUME] && vcount_next == 8'd0) vcount_next = volume_period;
  end

  always_comb begin
    result.send_command       = cmd;
    result.heartbeat          = hb;
    result.frame_done         = done;
    result.device_error       = err_next;
    result.source_code        = rv_source_next;
    result.mute_state         = rv_mute_next;
    result.power_off_state    = rv_off_next;
    result.volume_level       = rv_volume_next;
    result.key_events_on      = rv_keyev_next;
    result.room_state_request = kflags_next[KF_ROOM];
    result.volume_key_active  = kflags_next[KF_VOLUME];
    result.source_key_request = kflags_next[KF_SOURCE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait  <= 16'd0;
      gap       <= 16'd0;
      step      <= STEP_START;
      vcount    <= 8'd0;
      frem      <= '0;
      fpos      <= '0;
      err       <= 1'b0;
      rv_source <= 8'd0;
      rv_mute   <= 8'd0;
      rv_off    <= 8'd0;
      rv_volume <= 8'd0;
      rv_keyev  <= 8'd0;
      kflags    <= 3'b000;
      for (int i = 0; i < FRAME_STORE; i++) fbytes[i] <= 8'd0;
    end else if (fire) begin
      ack_wait  <= ack_wait_next;
      gap       <= gap_next;
      step      <= step_next;
      vcount    <= vcount_next;
      frem      <= frem_next;
      fpos      <= fpos_next;
      err       <= err_next;
      rv_source <= rv_source_next;
      rv_mute   <= rv_mute_next;
      rv_off    <= rv_off_next;
      rv_volume <= rv_volume_next;
      rv_keyev  <= rv_keyev_next;
      kflags    <= kflags_next;
      fbytes    <= fbytes_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/sdpc_result_queue.sv */
// ----------------------------------------------------------------------------
// sdpc_result_queue: output side of the poll controller
// Two entry queue of finished results, popped by the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpc_result_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdpc_pkg::result_t   result_in,
  input  wire logic                result_push,
  output logic                     res_full,
  output sdpc_pkg::result_t        result_out,
  output logic                     empty,
  input  wire logic                pop
);
  import sdpc_pkg::*;

  localparam int DEPTH = 2;

  result_t    mem [DEPTH];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'(DEPTH));
  assign empty    = (count == 2'd0);
  assign do_push  = result_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= result_in;
  end

  assign result_out = mem[rd_ptr];

endmodule

`default_nettype wire

/* rtl/serial_device_poll_controller.sv */
// ----------------------------------------------------------------------------
// serial_device_poll_controller: polls an audio device over a serial link
// Front queue, execution engine and result queue; one result per item.
// ----------------------------------------------------------------------------
// Each item is a poll tick (operation 0) or one received serial byte
// (operation 1) and yields exactly one result, in order. Items are taken
// one per clock while the front queue is not full: the front queue and the
// result queue hold two entries each, and the engine updates all poll, ack
// and frame state for each item as it hands the result on; the item is
// registered in the front queue and its result in the result queue before
// it shows on the result ports. full rises only when the front queue
// holds two items that the engine cannot pass on because the result queue
// is full. Configuration writes are always ready and take effect at once;
// write them only while no item is in flight.
`default_nettype none

module serial_device_poll_controller #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sdpc_pkg::CFG_DATA_W-1:0]  cfg_value,
  // item queue side
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             operation,
  input  wire logic [7:0]                       rx_byte,
  // result queue side
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [2:0]                            send_command,
  output logic                                  heartbeat,
  output logic                                  frame_done,
  output logic                                  device_error,
  output logic [7:0]                            source_code,
  output logic [7:0]                            mute_state,
  output logic [7:0]                            power_off_state,
  output logic [7:0]                            volume_level,
  output logic [7:0]                            key_events_on,
  output logic                                  room_state_request,
  output logic                                  volume_key_active,
  output logic                                  source_key_request
);
  import sdpc_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_full;
  result_t result_new;
  logic    result_push;
  result_t result_head;

  // config writes never stall
  assign cfg_ready = 1'b1;

  // accept and tag items
  sdpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  // poll sequence, ack wait and frame decode
  sdpc_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_value   (cfg_value),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .res_full    (res_full),
    .result      (result_new),
    .result_push (result_push)
  );

  // finished results wait here for the consumer
  sdpc_result_queue u_result_queue (
    .clk         (clk),
    .rst         (rst),
    .result_in   (result_new),
    .result_push (result_push),
    .res_full    (res_full),
    .result_out  (result_head),
    .empty       (empty),
    .pop         (pop)
  );

  // unpack the head result onto the ports
  assign send_command       = result_head.send_command;
  assign heartbeat          = result_head.heartbeat;
  assign frame_done         = result_head.frame_done;
  assign device_error       = result_head.device_error;
  assign source_code        = result_head.source_code;
  assign mute_state         = result_head.mute_state;
  assign power_off_state    = result_head.power_off_state;
  assign volume_level       = result_head.volume_level;
  assign key_events_on      = result_head.key_events_on;
  assign room_state_request = result_head.room_state_request;
  assign volume_key_active  = result_head.volume_key_active;
  assign source_key_request = result_head.source_key_request;

  // a byte result never carries a command or a heartbeat
  a_byte_result_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> (send_command == CMD_NONE && !heartbeat))
    else $error("frame result carries a command or heartbeat");

  // an accepted item is held in the front queue on the next cycle
  a_front_holds_item: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> item_valid)
    else $error("accepted item lost in front queue");

  // a heartbeat comes only with no command, a round's first command or a volume poll
  a_heartbeat_cmd: assert property (@(posedge clk) disable iff (rst)
    (!empty && heartbeat) |-> (send_command == CMD_NONE ||
      send_command == CMD_ENABLE_KEYS || send_command == CMD_GET_KEY ||
      send_command == CMD_GET_VOLUME))
    else $error("heartbeat with unexpected command");

  // the engine only hands a result over when the result queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    result_push |-> !res_full)
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire

/* tb/sv/serial_device_poll_controller_tb.sv */
// ----------------------------------------------------------------------------
// serial_device_poll_controller_tb: self-checking bench of the poll controller
// Feeds ticks and received bytes through the item queue and keeps a cycle-free
// copy of the poll, ack and frame state that works out the status of every
// item. Each popped result is compared field by field with the oldest status
// still due. Register settings change only while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_device_poll_controller_tb;
  import sdpc_pkg::*;

  localparam int FRAME_MAX      = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PERCENT   = 33;

  // index past the register list, the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_value = '0;
  logic                   push      = 1'b0;
  logic                   operation = 1'b0;
  logic [7:0]             rx_byte   = 8'h00;
  logic                   pop       = 1'b0;

  // block outputs
  logic       cfg_ready;
  logic       full;
  logic       empty;
  logic [2:0] send_command;
  logic       heartbeat;
  logic       frame_done;
  logic       device_error;
  logic [7:0] source_code;
  logic [7:0] mute_state;
  logic [7:0] power_off_state;
  logic [7:0] volume_level;
  logic [7:0] key_events_on;
  logic       room_state_request;
  logic       volume_key_active;
  logic       source_key_request;

  serial_device_poll_controller #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_value         (cfg_value),
    .push              (push),
    .full              (full),
    .operation         (operation),
    .rx_byte           (rx_byte),
    .empty             (empty),
    .pop               (pop),
    .send_command      (send_command),
    .heartbeat         (heartbeat),
    .frame_done        (frame_done),
    .device_error      (device_error),
    .source_code       (source_code),
    .mute_state        (mute_state),
    .power_off_state   (power_off_state),
    .volume_level      (volume_level),
    .key_events_on     (key_events_on),
    .room_state_request(room_state_request),
    .volume_key_active (volume_key_active),
    .source_key_request(source_key_request)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ticks and bytes waiting to be offered, status values due from the block
  item_t   item_queue[$];
  result_t status_queue[$];

  int error_count = 0;
  int items_added = 0;

  // traffic shaping shared by driver and monitor
  bit no_idle      = 1'b0;  // no random gaps on either side
  bit hold_request = 1'b0;  // ask the monitor for one long pop hold-off
  bit hold_taken   = 1'b0;
  int hold_left    = 0;
  int stall_cycles = 0;

  // --------------------------------------------------------------------------
  // shadow copy of the controller state
  // --------------------------------------------------------------------------
  logic [15:0] cfg_ack_timeout = ACK_TIMEOUT_RESET;
  logic [15:0] cfg_round_gap   = ROUND_GAP_RESET;
  logic [7:0]  cfg_vol_period  = VOLUME_PERIOD_RESET;

  logic [15:0] ack_wait_left;
  logic [15:0] gap_left;
  logic [2:0]  poll_phase;
  logic [7:0]  vol_poll_left;
  logic [7:0]  frame_mem [FRAME_STORE];
  logic [7:0]  frame_left;
  logic [7:0]  frame_pos;
  logic        err_sticky;
  logic [7:0]  rv_source;
  logic [7:0]  rv_mute;
  logic [7:0]  rv_off;
  logic [7:0]  rv_volume;
  logic [7:0]  rv_keyev;
  logic [2:0]  key_flags;

  // a command goes out only when no ack is awaited, and then arms the wait
  function automatic cmd_t issue_cmd(input cmd_t wanted);
    if (ack_wait_left != 16'd0) return CMD_NONE;
    ack_wait_left = cfg_ack_timeout;
    return wanted;
  endfunction

  // decode a completed frame from the stored bytes
  function automatic void decode_frame();
    logic [15:0] op;
    op = {frame_mem[1], frame_mem[2]};
    if (frame_mem[0][HDR_ERROR_BIT]) begin
      err_sticky = 1'b1;
    end else if (frame_mem[0][HDR_NOTIFY_BIT]) begin
      // notifications only matter when they carry a key event
      if (op == OP_KEY_EVENT) begin
        key_flags = 3'b000;
        if (frame_mem[3] == 8'h00) begin
          if (frame_mem[5] == KEY_POWER || frame_mem[5] == KEY_MUTE) begin
            key_flags[KF_ROOM] = 1'b1;
          end else if (frame_mem[5] == KEY_VOL_UP || frame_mem[5] == KEY_VOL_DOWN) begin
            key_flags[KF_VOLUME] = 1'b1;
          end else if (frame_mem[5] == KEY_SOURCE) begin
            key_flags[KF_SOURCE] = 1'b1;
          end
        end
      end
    end else begin
      case (op)
        OP_ACK:        ack_wait_left = 16'd0;
        OP_SOURCE:     rv_source = frame_mem[3];
        OP_ROOM: begin
          rv_mute = frame_mem[4];
          rv_off  = frame_mem[5];
        end
        OP_VOLUME:     rv_volume = frame_mem[3];
        OP_KEY_ENABLE: rv_keyev = frame_mem[3];
        default: ;
      endcase
    end
  endfunction

  // advance the shadow state by one item and return the status it causes
  function automatic result_t status_after_item(input item_kind_t kind,
                                                input logic [7:0] data);
    result_t res;
    cmd_t    cmd;
    cmd_t    step_cmd;
    logic    hb;
    logic    done;
    logic    check_end;
    logic [7:0] len;
    cmd       = CMD_NONE;
    hb        = 1'b0;
    done      = 1'b0;
    check_end = 1'b0;
    if (kind == ITEM_TICK) begin
      if (ack_wait_left != 16'd0) begin
        // ack wait runs down; on timeout a partial frame is dropped
        ack_wait_left = ack_wait_left - 16'd1;
        if (ack_wait_left == 16'd0) begin
          frame_left = 8'd0;
          frame_pos  = 8'd0;
        end
      end else begin
        // fast volume poll while a volume key is held
        if (vol_poll_left != 8'd0) begin
          if (vol_poll_left == cfg_vol_period) cmd = issue_cmd(CMD_GET_VOLUME);
          if (key_flags[KF_VOLUME]) vol_poll_left = vol_poll_left - 8'd1;
          else vol_poll_left = 8'd0;
          gap_left = cfg_round_gap;
        end
        if (gap_left != 16'd0) begin
          gap_left = gap_left - 16'd1;
        end else begin
          step_cmd = CMD_NONE;
          case (poll_phase)
            3'd0: begin
              hb = 1'b1;
              if (rv_keyev == 8'h00) begin
                poll_phase = 3'd1;
                step_cmd   = issue_cmd(CMD_ENABLE_KEYS);
              end else begin
                poll_phase = 3'd2;
                step_cmd   = issue_cmd(CMD_GET_KEY);
              end
            end
            3'd1: begin
              poll_phase = 3'd2;
              step_cmd   = issue_cmd(CMD_GET_KEY);
            end
            3'd2: begin
              poll_phase = 3'd3;
              step_cmd   = issue_cmd(CMD_GET_ROOM);
            end
            3'd3: begin
              poll_phase = 3'd4;
              step_cmd   = issue_cmd(CMD_GET_VOLUME);
            end
            3'd4: begin
              gap_left   = cfg_round_gap;
              poll_phase = 3'd0;
            end
            default: poll_phase = 3'd0;
          endcase
          if (cmd == CMD_NONE) cmd = step_cmd;
        end
      end
    end else begin
      if (frame_left == 8'd0) begin
        // length byte counts itself, clamped, zero starts nothing
        len = (data > 8'(FRAME_MAX)) ? 8'(FRAME_MAX) : data;
        if (len != 8'd0) begin
          frame_left = len - 8'd1;
          frame_pos  = 8'd0;
          check_end  = 1'b1;
        end
      end else begin
        if (frame_pos < 8'(FRAME_STORE)) frame_mem[frame_pos[FRAME_STORE_W-1:0]] = data;
        frame_pos  = frame_pos + 8'd1;
        frame_left = frame_left - 8'd1;
        check_end  = 1'b1;
      end
      if (check_end && frame_left == 8'd0) begin
        frame_pos = 8'd0;
        decode_frame();
        done = 1'b1;
      end
    end
    // reload of the fast volume poll after every item
    if (key_flags[KF_VOLUME] && vol_poll_left == 8'd0) vol_poll_left = cfg_vol_period;
    res.send_command       = cmd;
    res.heartbeat          = hb;
    res.frame_done         = done;
    res.device_error       = err_sticky;
    res.source_code        = rv_source;
    res.mute_state         = rv_mute;
    res.power_off_state    = rv_off;
    res.volume_level       = rv_volume;
    res.key_events_on      = rv_keyev;
    res.room_state_request = key_flags[KF_ROOM];
    res.volume_key_active  = key_flags[KF_VOLUME];
    res.source_key_request = key_flags[KF_SOURCE];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // item driver: offers queued items, holds them while full is high
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      // transfer at this edge, so the shadow state takes the item now
      if (push && !full) begin
        status_queue.push_back(status_after_item(item_kind_t'(operation), rx_byte));
      end
      if (push && full) begin
        // item stays on the ports until it is taken
      end else if (item_queue.size() != 0 &&
                   (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        nxt = item_queue.pop_front();
        push      <= 1'b1;
        operation <= nxt.kind;
        rx_byte   <= nxt.data;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: pops at random and checks every field
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_status
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (status_queue.size() == 0) begin
          $display("%0t: result transfer with no status due, expected none actual cmd %0h",
                   $time, send_command);
          error_count++;
        end else begin
          want = status_queue.pop_front();
          check_field("send_command", want.send_command, send_command);
          check_field("heartbeat", want.heartbeat, heartbeat);
          check_field("frame_done", want.frame_done, frame_done);
          check_field("device_error", want.device_error, device_error);
          check_field("source_code", want.source_code, source_code);
          check_field("mute_state", want.mute_state, mute_state);
          check_field("power_off_state", want.power_off_state, power_off_state);
          check_field("volume_level", want.volume_level, volume_level);
          check_field("key_events_on", want.key_events_on, key_events_on);
          check_field("room_state_request", want.room_state_request, room_state_request);
          check_field("volume_key_active", want.volume_key_active, volume_key_active);
          check_field("source_key_request", want.source_key_request, source_key_request);
        end
      end
      // one long hold-off so that both queues fill and full stalls the sender
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // watchdog: cycles in a row without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input item_kind_t kind, input logic [7:0] data);
    item_t it;
    it.kind = kind;
    it.data = data;
    item_queue.push_back(it);
    items_added++;
  endtask

  task automatic add_ticks(input int count);
    for (int k = 0; k < count; k++) add_item(ITEM_TICK, 8'($urandom));
  endtask

  // length byte, then header, opcode, three payload bytes and random filler
  task automatic add_frame(input logic [7:0] len, input logic [7:0] hdr,
                           input logic [15:0] op, input logic [7:0] d3,
                           input logic [7:0] d4, input logic [7:0] d5);
    int         body;
    logic [7:0] b;
    add_item(ITEM_BYTE, len);
    body = (int'(len) > FRAME_MAX) ? FRAME_MAX - 1 : ((len == 8'd0) ? 0 : int'(len) - 1);
    for (int k = 0; k < body; k++) begin
      case (k)
        0:       b = hdr;
        1:       b = op[15:8];
        2:       b = op[7:0];
        3:       b = d3;
        4:       b = d4;
        5:       b = d5;
        default: b = 8'($urandom);
      endcase
      add_item(ITEM_BYTE, b);
    end
  endtask

  // register write over the config channel, shadow copy follows the transfer
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ACK_TIMEOUT:   cfg_ack_timeout = val;
      REG_ROUND_GAP:     cfg_round_gap   = val;
      REG_VOLUME_PERIOD: cfg_vol_period  = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender stops until nothing is queued, on the ports or due
  task automatic wait_drained();
    while (item_queue.size() != 0 || push || status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register setting followed by a random mix of ticks and frames
  task automatic run_phase(input logic [15:0] ack, input logic [15:0] gap,
                           input logic [7:0] vol, input int target,
                           input bit burst, input bit hold);
    int          pick;
    int          kind;
    logic [7:0]  len;
    logic [7:0]  hdr;
    logic [15:0] op;
    logic [7:0]  d3;
    logic [7:0]  d5;
    wait_drained();
    write_reg(REG_ACK_TIMEOUT, ack);
    write_reg(REG_ROUND_GAP, gap);
    write_reg(REG_VOLUME_PERIOD, {8'h00, vol});
    write_reg(REG_UNMAPPED, 16'($urandom));
    no_idle     = burst;
    hold_request = hold;
    items_added = 0;
    while (items_added < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_ticks($urandom_range(1, 8));
      end else if (pick < 40) begin
        // long tick runs let ack timeouts and round gaps expire
        add_ticks($urandom_range(10, 40));
      end else if (pick < 85) begin
        kind = $urandom_range(0, 7);
        hdr  = 8'($urandom) & 8'h77;
        d3   = 8'($urandom);
        d5   = 8'($urandom);
        op   = 16'($urandom);
        if ($urandom_range(0, 99) < 3) len = 8'($urandom_range(8, 255));
        else if ($urandom_range(0, 99) < 80) len = 8'd7;
        else len = 8'($urandom_range(1, 7));
        case (kind)
          0: op = OP_ACK;
          1: op = OP_SOURCE;
          2: op = OP_ROOM;
          3: op = OP_VOLUME;
          4: begin
            op = OP_KEY_ENABLE;
            if ($urandom_range(0, 1) == 0) d3 = 8'h00;
          end
          5: begin
            // key notification, mostly with a known key code
            hdr = hdr | 8'h08;
            op  = OP_KEY_EVENT;
            if ($urandom_range(0, 99) < 70) d3 = 8'h00;
            case ($urandom_range(0, 5))
              0: d5 = KEY_POWER;
              1: d5 = KEY_MUTE;
              2: d5 = KEY_VOL_UP;
              3: d5 = KEY_VOL_DOWN;
              4: d5 = KEY_SOURCE;
              default: ;
            endcase
          end
          6: hdr = 8'($urandom) | 8'h80;
          default: begin
            hdr = 8'($urandom) & 8'h7F;
            op  = {8'h01, 8'($urandom)};
          end
        endcase
        add_frame(len, hdr, op, d3, 8'($urandom), d5);
      end else if (pick < 92) begin
        // broken frame: cut short and followed by ticks
        len = 8'($urandom_range(3, 7));
        add_item(ITEM_BYTE, len);
        for (int k = 0; k < $urandom_range(1, int'(len) - 2); k++) begin
          add_item(ITEM_BYTE, 8'($urandom));
        end
        add_ticks($urandom_range(1, 12));
      end else begin
        add_item(ITEM_BYTE, 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    // shadow state after reset
    ack_wait_left = 16'd0;
    gap_left      = 16'd0;
    poll_phase    = 3'd0;
    vol_poll_left = 8'd0;
    frame_left    = 8'd0;
    frame_pos     = 8'd0;
    err_sticky    = 1'b0;
    rv_source     = 8'h00;
    rv_mute       = 8'h00;
    rv_off        = 8'h00;
    rv_volume     = 8'h00;
    rv_keyev      = 8'h00;
    key_flags     = 3'b000;
    for (int k = 0; k < FRAME_STORE; k++) frame_mem[k] = 8'h00;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with short waits so that every effect shows quickly
    write_reg(REG_ACK_TIMEOUT, 16'd4);
    write_reg(REG_ROUND_GAP, 16'd2);
    write_reg(REG_VOLUME_PERIOD, 16'd3);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    // round start with key events off, then commands held back by the ack wait
    add_ticks(3);
    // ack frame clears the wait
    add_frame(8'd4, 8'h00, OP_ACK, 8'h00, 8'h00, 8'h00);
    // zero length byte, then a length-one frame that reuses the stored bytes
    add_item(ITEM_BYTE, 8'h00);
    add_item(ITEM_BYTE, 8'h01);
    // key events reported on
    add_frame(8'd5, 8'h00, OP_KEY_ENABLE, 8'h01, 8'h00, 8'h00);
    // volume key held, then the fast volume poll runs
    add_frame(8'd7, 8'h08, OP_KEY_EVENT, 8'h00, 8'h00, KEY_VOL_UP);
    add_ticks(4);
    // error header sets the sticky flag
    add_frame(8'd2, 8'h80, 16'h0000, 8'h00, 8'h00, 8'h00);

    // random part over several settings, the extremes among them
    run_phase(16'd1, 16'd0, 8'd1, 110, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 60, 1'b0, 1'b0);
    run_phase(16'd0, 16'd0, 8'd0, 90, 1'b0, 1'b0);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)),
              8'($urandom_range(1, 6)), 110, 1'b1, 1'b0);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)),
              8'($urandom_range(1, 6)), 110, 1'b1, 1'b1);
    run_phase(ACK_TIMEOUT_RESET, 16'($urandom_range(0, 20)), VOLUME_PERIOD_RESET,
              90, 1'b0, 1'b0);
    run_phase(16'($urandom_range(1, 30)), 16'($urandom_range(0, 30)),
              8'($urandom_range(1, 20)), 90, 1'b0, 1'b0);
    run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
              8'($urandom_range(1, 4)), 90, 1'b0, 1'b0);

    // drain, then a few quiet cycles to catch stray results
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
